FILE: sv/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
// No dependencies; used by the interfaces, controller, datapath and top level.
`default_nettype none

package spq_pkg;

  localparam int ID_W      = 32;
  localparam int PRI_W     = 32;
  localparam int CMD_W     = 2;
  localparam int STATUS_W  = 2;
  localparam int CNT_OUT_W = 5;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_POP    = 2'd2;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2,
    ST_NULL = 2'd3
  } status_t;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [PRI_W-1:0] pri;
  } entry_t;

  // pointer update
  typedef enum logic [2:0] {
    P_HOLD  = 3'd0,
    P_ZERO  = 3'd1,
    P_COUNT = 3'd2,
    P_INC   = 3'd3,
    P_DEC   = 3'd4
  } p_op_t;

  typedef enum logic [1:0] {
    CNT_HOLD = 2'd0,
    CNT_INC  = 2'd1,
    CNT_DEC  = 2'd2
  } cnt_op_t;

  // read address relative to the next pointer value
  typedef enum logic [1:0] {
    RD_BELOW = 2'd0,
    RD_AT    = 2'd1,
    RD_ABOVE = 2'd2
  } rd_mode_t;

  typedef struct packed {
    logic     latch_req;
    p_op_t    p_op;
    cnt_op_t  cnt_op;
    logic     rd_en;
    rd_mode_t rd_mode;
    logic     wr_en;
    logic     wr_new;
    logic     set_status;
    status_t  status_val;
    logic     clr_pop;
    logic     cap_pop;
    logic     load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] req_cmd;
    logic             id_null;
    logic             cnt_zero;
    logic             cnt_full;
    logic             p_zero;
    logic             p_one;
    logic             p1_lt_cnt;
    logic             p2_lt_cnt;
    logic             pri_less;
    logic             id_match;
  } dp_stat_t;

endpackage

`default_nettype wire

FILE: sv/spq_if.sv
// Valid/ready channel interfaces for the sorted priority queue.
// Depends on spq_pkg for field widths.
`default_nettype none

interface spq_in_if;
  logic                           valid;
  logic                           ready;
  logic [spq_pkg::CMD_W-1:0]      command;
  logic [spq_pkg::ID_W-1:0]       object_id;
  logic [spq_pkg::PRI_W-1:0]      priority_req;

  modport source (output valid, command, object_id, priority_req, input ready);
  modport sink   (input valid, command, object_id, priority_req, output ready);
endinterface

interface spq_out_if;
  logic                           valid;
  logic                           ready;
  logic [spq_pkg::STATUS_W-1:0]   status;
  logic [spq_pkg::ID_W-1:0]       popped_id;
  logic [spq_pkg::PRI_W-1:0]      popped_priority;
  logic [spq_pkg::CNT_OUT_W-1:0]  entry_count;

  modport source (output valid, status, popped_id, popped_priority, entry_count,
                  input ready);
  modport sink   (input valid, status, popped_id, popped_priority, entry_count,
                  output ready);
endinterface

`default_nettype wire

FILE: sv/sorted_priority_queue_top.sv
// Sorted priority queue: up to DEPTH (id, priority) entries, highest priority
// at the head, arrival order kept among equal priorities.
// Commands arrive on in_ch; one result per command leaves on out_ch through
// an output register, so the next command is taken while a result waits.
// Work per command, N = entries held at the start:
//   insert   : each entry of lower priority moves up one slot;
//              at most N entries move
//   delete   : scan to the match and move the entries above it down, or scan all N
//   pop      : the head is read out and the other N - 1 entries move down
//   null, full, empty or unused command : no memory access
// The entry memory has one read and one write port and moves one entry per cycle.
// One command is worked on at a time; in_ch.ready is high only while idle.
// If out_ch.ready is held low, a finished result waits in the controller and
// no further command is accepted until the output register frees up.
// Reset empties the queue at once; memory contents are left as they are.
// Depends on spq_pkg, spq_if, spq_ctrl and spq_datapath.
`default_nettype none

module sorted_priority_queue_top #(
  parameter int DEPTH = 16
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  spq_in_if.sink      in_ch,
  spq_out_if.source   out_ch
);

  spq_pkg::dp_cmd_t  dp_cmd;
  spq_pkg::dp_stat_t dp_stat;

  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (dp_stat),
    .cmd       (dp_cmd)
  );

  spq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_command          (in_ch.command),
    .in_object_id        (in_ch.object_id),
    .in_priority_req     (in_ch.priority_req),
    .cmd                 (dp_cmd),
    .stat                (dp_stat),
    .out_status          (out_ch.status),
    .out_popped_id       (out_ch.popped_id),
    .out_popped_priority (out_ch.popped_priority),
    .out_entry_count     (out_ch.entry_count)
  );

  a_no_inc_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (dp_cmd.cnt_op == spq_pkg::CNT_INC) |-> !dp_stat.cnt_full)
    else $error("entry count grows past DEPTH");

  a_no_dec_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (dp_cmd.cnt_op == spq_pkg::CNT_DEC) |-> !dp_stat.cnt_zero)
    else $error("entry count drops below zero");

  a_pop_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.status != spq_pkg::ST_OK))
      |-> (out_ch.popped_id == '0) && (out_ch.popped_priority == '0))
    else $error("popped fields set on a failed command");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("second item accepted while one is in progress");

endmodule

`default_nettype wire

FILE: sv/spq_datapath.sv
// Datapath: entry memory, request and result registers, pointer and count.
// Depends on spq_pkg; driven by spq_ctrl through dp_cmd_t.
`default_nettype none

module spq_datapath #(
  parameter int DEPTH = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [spq_pkg::CMD_W-1:0]     in_command,
  input  wire logic [spq_pkg::ID_W-1:0]      in_object_id,
  input  wire logic [spq_pkg::PRI_W-1:0]     in_priority_req,
  input  wire spq_pkg::dp_cmd_t              cmd,
  output spq_pkg::dp_stat_t                  stat,
  output logic [spq_pkg::STATUS_W-1:0]       out_status,
  output logic [spq_pkg::ID_W-1:0]           out_popped_id,
  output logic [spq_pkg::PRI_W-1:0]          out_popped_priority,
  output logic [spq_pkg::CNT_OUT_W-1:0]      out_entry_count
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = $clog2(DEPTH);

  logic [spq_pkg::CMD_W-1:0]     req_cmd_r;
  logic [spq_pkg::ID_W-1:0]      req_id_r;
  logic [spq_pkg::PRI_W-1:0]     req_pri_r;
  logic [CW-1:0]                 cnt_r, cnt_nxt;
  logic [CW-1:0]                 p_r, p_nxt;
  logic [CW-1:0]                 rd_ptr;
  logic [CW:0]                   p_plus1, p_plus2;
  logic [AW-1:0]                 rd_addr, wr_addr;
  spq_pkg::entry_t               mem [DEPTH];
  spq_pkg::entry_t               rdata_r;
  spq_pkg::entry_t               wdata;
  spq_pkg::status_t              status_r;
  logic [spq_pkg::ID_W-1:0]      pop_id_r;
  logic [spq_pkg::PRI_W-1:0]     pop_pri_r;
  logic [spq_pkg::STATUS_W-1:0]  out_status_r;
  logic [spq_pkg::ID_W-1:0]      out_id_r;
  logic [spq_pkg::PRI_W-1:0]     out_pri_r;
  logic [spq_pkg::CNT_OUT_W-1:0] out_cnt_r;

  always_comb begin
    unique case (cmd.p_op)
      spq_pkg::P_ZERO:  p_nxt = '0;
      spq_pkg::P_COUNT: p_nxt = cnt_r;
      spq_pkg::P_INC:   p_nxt = p_r + CW'(1);
      spq_pkg::P_DEC:   p_nxt = p_r - CW'(1);
      default:          p_nxt = p_r;
    endcase
  end

  always_comb begin
    unique case (cmd.cnt_op)
      spq_pkg::CNT_INC: cnt_nxt = cnt_r + CW'(1);
      spq_pkg::CNT_DEC: cnt_nxt = cnt_r - CW'(1);
      default:          cnt_nxt = cnt_r;
    endcase
  end

  always_comb begin
    unique case (cmd.rd_mode)
      spq_pkg::RD_BELOW: rd_ptr = p_nxt - CW'(1);
      spq_pkg::RD_ABOVE: rd_ptr = p_nxt + CW'(1);
      default:           rd_ptr = p_nxt;
    endcase
  end

  assign rd_addr = rd_ptr[AW-1:0];
  assign wr_addr = p_r[AW-1:0];
  assign wdata   = cmd.wr_new ? spq_pkg::entry_t'{id: req_id_r, pri: req_pri_r} : rdata_r;
  assign p_plus1 = {1'b0, p_r} + (CW+1)'(1);
  assign p_plus2 = {1'b0, p_r} + (CW+1)'(2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      p_r   <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      p_r   <= p_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wdata;
    end
    if (cmd.rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_req) begin
      req_cmd_r <= in_command;
      req_id_r  <= in_object_id;
      req_pri_r <= in_priority_req;
    end
    if (cmd.set_status) begin
      status_r <= cmd.status_val;
    end
    if (cmd.clr_pop) begin
      pop_id_r  <= '0;
      pop_pri_r <= '0;
    end else if (cmd.cap_pop) begin
      pop_id_r  <= rdata_r.id;
      pop_pri_r <= rdata_r.pri;
    end
    if (cmd.load_out) begin
      out_status_r <= status_r;
      out_id_r     <= pop_id_r;
      out_pri_r    <= pop_pri_r;
      out_cnt_r    <= spq_pkg::CNT_OUT_W'(cnt_r);
    end
  end

  assign stat.req_cmd   = req_cmd_r;
  assign stat.id_null   = (req_id_r == '0);
  assign stat.cnt_zero  = (cnt_r == '0);
  assign stat.cnt_full  = (cnt_r == CW'(DEPTH));
  assign stat.p_zero    = (p_r == '0);
  assign stat.p_one     = (p_r == CW'(1));
  assign stat.p1_lt_cnt = (p_plus1 < {1'b0, cnt_r});
  assign stat.p2_lt_cnt = (p_plus2 < {1'b0, cnt_r});
  assign stat.pri_less  = (rdata_r.pri < req_pri_r);
  assign stat.id_match  = (rdata_r.id == req_id_r);

  assign out_status          = out_status_r;
  assign out_popped_id       = out_id_r;
  assign out_popped_priority = out_pri_r;
  assign out_entry_count     = out_cnt_r;

endmodule

`default_nettype wire

FILE: sv/spq_ctrl.sv
// Controller state machine: sequences insert, delete and pop over the datapath.
// Depends on spq_pkg; drives spq_datapath through dp_cmd_t.
`default_nettype none

module spq_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire spq_pkg::dp_stat_t stat,
  output spq_pkg::dp_cmd_t       cmd
);

  typedef enum logic [10:0] {
    S_IDLE     = 11'b000_0000_0001,
    S_DECODE   = 11'b000_0000_0010,
    S_INS_RD   = 11'b000_0000_0100,
    S_INS_CMP  = 11'b000_0000_1000,
    S_DEL_RD   = 11'b000_0001_0000,
    S_DEL_CMP  = 11'b000_0010_0000,
    S_POP_RD   = 11'b000_0100_0000,
    S_POP_CAP  = 11'b000_1000_0000,
    S_SH_START = 11'b001_0000_0000,
    S_SHIFT    = 11'b010_0000_0000,
    S_RESP     = 11'b100_0000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt      = state_r;
    cmd.latch_req  = 1'b0;
    cmd.p_op       = spq_pkg::P_HOLD;
    cmd.cnt_op     = spq_pkg::CNT_HOLD;
    cmd.rd_en      = 1'b0;
    cmd.rd_mode    = spq_pkg::RD_AT;
    cmd.wr_en      = 1'b0;
    cmd.wr_new     = 1'b0;
    cmd.set_status = 1'b0;
    cmd.status_val = spq_pkg::ST_OK;
    cmd.clr_pop    = 1'b0;
    cmd.cap_pop    = 1'b0;
    cmd.load_out   = 1'b0;
    in_ready       = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch_req = 1'b1;
          cmd.clr_pop   = 1'b1;
          state_nxt     = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.set_status = 1'b1;
        state_nxt      = S_RESP;
        unique case (stat.req_cmd)
          spq_pkg::CMD_INSERT: begin
            if (stat.id_null) begin
              cmd.status_val = spq_pkg::ST_NULL;
            end else if (stat.cnt_full) begin
              cmd.status_val = spq_pkg::ST_FULL;
            end else begin
              cmd.p_op  = spq_pkg::P_COUNT;
              state_nxt = S_INS_RD;
            end
          end
          spq_pkg::CMD_DELETE: begin
            if (stat.id_null) begin
              cmd.status_val = spq_pkg::ST_NULL;
            end else if (stat.cnt_zero) begin
              cmd.status_val = spq_pkg::ST_MISS;
            end else begin
              cmd.p_op  = spq_pkg::P_ZERO;
              state_nxt = S_DEL_RD;
            end
          end
          spq_pkg::CMD_POP: begin
            if (stat.cnt_zero) begin
              cmd.status_val = spq_pkg::ST_MISS;
            end else begin
              cmd.p_op  = spq_pkg::P_ZERO;
              state_nxt = S_POP_RD;
            end
          end
          default: begin
            cmd.status_val = spq_pkg::ST_OK;
          end
        endcase
      end
      S_INS_RD: begin
        if (stat.p_zero) begin
          cmd.wr_en  = 1'b1;
          cmd.wr_new = 1'b1;
          cmd.cnt_op = spq_pkg::CNT_INC;
          state_nxt  = S_RESP;
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.rd_mode = spq_pkg::RD_BELOW;
          state_nxt   = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        cmd.wr_en = 1'b1;
        if (stat.pri_less) begin
          // move the lower-priority entry up one slot
          cmd.p_op = spq_pkg::P_DEC;
          if (stat.p_one) begin
            state_nxt = S_INS_RD;
          end else begin
            cmd.rd_en   = 1'b1;
            cmd.rd_mode = spq_pkg::RD_BELOW;
          end
        end else begin
          cmd.wr_new = 1'b1;
          cmd.cnt_op = spq_pkg::CNT_INC;
          state_nxt  = S_RESP;
        end
      end
      S_DEL_RD: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_mode = spq_pkg::RD_AT;
        state_nxt   = S_DEL_CMP;
      end
      S_DEL_CMP: begin
        if (stat.id_match) begin
          state_nxt = S_SH_START;
        end else if (stat.p1_lt_cnt) begin
          cmd.p_op    = spq_pkg::P_INC;
          cmd.rd_en   = 1'b1;
          cmd.rd_mode = spq_pkg::RD_AT;
        end else begin
          cmd.set_status = 1'b1;
          cmd.status_val = spq_pkg::ST_MISS;
          state_nxt      = S_RESP;
        end
      end
      S_POP_RD: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_mode = spq_pkg::RD_AT;
        state_nxt   = S_POP_CAP;
      end
      S_POP_CAP: begin
        cmd.cap_pop = 1'b1;
        state_nxt   = S_SH_START;
      end
      S_SH_START: begin
        if (stat.p1_lt_cnt) begin
          cmd.rd_en   = 1'b1;
          cmd.rd_mode = spq_pkg::RD_ABOVE;
          state_nxt   = S_SHIFT;
        end else begin
          cmd.cnt_op = spq_pkg::CNT_DEC;
          state_nxt  = S_RESP;
        end
      end
      S_SHIFT: begin
        // close the gap: entry above moves down one slot
        cmd.wr_en = 1'b1;
        cmd.p_op  = spq_pkg::P_INC;
        if (stat.p2_lt_cnt) begin
          cmd.rd_en   = 1'b1;
          cmd.rd_mode = spq_pkg::RD_ABOVE;
        end else begin
          cmd.cnt_op = spq_pkg::CNT_DEC;
          state_nxt  = S_RESP;
        end
      end
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

FILE: test/tb.sv
`timescale 1ns / 100ps
// Testbench for sorted_priority_queue_top: directed table, then random command
// sequences checked field by field against a behavioral queue model.
// Depends on spq_pkg, spq_if and the sorted_priority_queue_top RTL.

module tb;

  localparam int QDEPTH = 16;
  localparam logic [spq_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int N_ROWS = 25;
  localparam int RANDOM_PER_PHASE = 550;

  typedef struct packed {
    spq_pkg::status_t          status;
    logic [spq_pkg::ID_W-1:0]  pid;
    logic [spq_pkg::PRI_W-1:0] ppri;
    logic [4:0]                cnt;
  } spq_result_t;

  typedef struct packed {
    logic [spq_pkg::CMD_W-1:0] cmd;
    logic [spq_pkg::ID_W-1:0]  id;
    logic [spq_pkg::PRI_W-1:0] pri;
    bit                        typed;
    spq_pkg::status_t          st;
    logic [spq_pkg::ID_W-1:0]  pid;
    logic [spq_pkg::PRI_W-1:0] ppri;
    logic [4:0]                cnt;
  } stim_row_t;

  logic clk;
  logic rst_n;

  spq_in_if  in_ch ();
  spq_out_if out_ch ();

  sorted_priority_queue_top #(.DEPTH(QDEPTH)) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  spq_pkg::entry_t held_entries [QDEPTH];
  int              model_count = 0;
  spq_result_t     expected_results [$];
  int              send_idle_pct = 0;
  int              recv_idle_pct = 0;
  int              mismatch_count = 0;
  int              items_sent = 0;
  int              results_checked = 0;
  int              status_seen [4] = '{0, 0, 0, 0};

  // typed expectations follow the queue contents row by row
  stim_row_t dir_rows [N_ROWS] = '{
    '{spq_pkg::CMD_POP, 32'd0, 32'd0, 1'b1, spq_pkg::ST_MISS, 32'd0, 32'd0, 5'd0},
    '{spq_pkg::CMD_DELETE, 32'd5, 32'd0, 1'b1, spq_pkg::ST_MISS, 32'd0, 32'd0, 5'd0},
    '{spq_pkg::CMD_INSERT, 32'd0, 32'd7, 1'b1, spq_pkg::ST_NULL, 32'd0, 32'd0, 5'd0},
    '{spq_pkg::CMD_DELETE, 32'd0, 32'd0, 1'b1, spq_pkg::ST_NULL, 32'd0, 32'd0, 5'd0},
    '{CMD_UNUSED, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, spq_pkg::ST_OK, 32'd0, 32'd0, 5'd0},
    '{spq_pkg::CMD_INSERT, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, spq_pkg::ST_OK, 32'd0, 32'd0,
      5'd1},
    '{spq_pkg::CMD_INSERT, 32'd1, 32'd0, 1'b1, spq_pkg::ST_OK, 32'd0, 32'd0, 5'd2},
    '{spq_pkg::CMD_INSERT, 32'd2, 32'd0, 1'b1, spq_pkg::ST_OK, 32'd0, 32'd0, 5'd3},
    '{spq_pkg::CMD_INSERT, 32'd3, 32'h80000000, 1'b1, spq_pkg::ST_OK, 32'd0, 32'd0, 5'd4},
    '{spq_pkg::CMD_INSERT, 32'd4, 32'hFFFFFFFF, 1'b1, spq_pkg::ST_OK, 32'd0, 32'd0, 5'd5},
    '{spq_pkg::CMD_INSERT, 32'd2, 32'h80000000, 1'b1, spq_pkg::ST_OK, 32'd0, 32'd0, 5'd6},
    '{spq_pkg::CMD_POP, 32'd7, 32'd3, 1'b1, spq_pkg::ST_OK, 32'hFFFFFFFF, 32'hFFFFFFFF,
      5'd5},
    '{spq_pkg::CMD_DELETE, 32'd2, 32'd0, 1'b1, spq_pkg::ST_OK, 32'd0, 32'd0, 5'd4},
    '{spq_pkg::CMD_DELETE, 32'd2, 32'd0, 1'b1, spq_pkg::ST_OK, 32'd0, 32'd0, 5'd3},
    '{spq_pkg::CMD_DELETE, 32'd2, 32'd0, 1'b1, spq_pkg::ST_MISS, 32'd0, 32'd0, 5'd3},
    '{spq_pkg::CMD_DELETE, 32'hDEADBEEF, 32'd0, 1'b1, spq_pkg::ST_MISS, 32'd0, 32'd0, 5'd3},
    '{CMD_UNUSED, 32'd9, 32'd9, 1'b1, spq_pkg::ST_OK, 32'd0, 32'd0, 5'd3},
    '{spq_pkg::CMD_INSERT, 32'd0, 32'hFFFFFFFF, 1'b1, spq_pkg::ST_NULL, 32'd0, 32'd0, 5'd3},
    '{spq_pkg::CMD_POP, 32'd0, 32'd0, 1'b1, spq_pkg::ST_OK, 32'd4, 32'hFFFFFFFF, 5'd2},
    '{spq_pkg::CMD_POP, 32'd0, 32'd0, 1'b1, spq_pkg::ST_OK, 32'd3, 32'h80000000, 5'd1},
    '{spq_pkg::CMD_POP, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, spq_pkg::ST_OK, 32'd1, 32'd0,
      5'd0},
    '{spq_pkg::CMD_POP, 32'd0, 32'd0, 1'b1, spq_pkg::ST_MISS, 32'd0, 32'd0, 5'd0},
    '{spq_pkg::CMD_INSERT, 32'h55555555, 32'hAAAAAAAA, 1'b0, spq_pkg::ST_OK, 32'd0, 32'd0,
      5'd0},
    '{spq_pkg::CMD_INSERT, 32'hAAAAAAAA, 32'h55555555, 1'b0, spq_pkg::ST_OK, 32'd0, 32'd0,
      5'd0},
    '{spq_pkg::CMD_DELETE, 32'h55555555, 32'd0, 1'b0, spq_pkg::ST_OK, 32'd0, 32'd0, 5'd0}
  };

  function automatic void remove_entry(input int pos);
    for (int i = pos; i + 1 < model_count; i++) begin
      held_entries[i] = held_entries[i + 1];
    end
    model_count--;
  endfunction

  function automatic spq_result_t apply_to_queue(input logic [spq_pkg::CMD_W-1:0] cmd,
                                                 input logic [spq_pkg::ID_W-1:0] id,
                                                 input logic [spq_pkg::PRI_W-1:0] pri);
    spq_result_t r;
    int pos;
    int hit;
    r.status = spq_pkg::ST_OK;
    r.pid    = '0;
    r.ppri   = '0;
    case (cmd)
      spq_pkg::CMD_INSERT: begin
        if (id == '0) begin
          r.status = spq_pkg::ST_NULL;
        end else if (model_count >= QDEPTH) begin
          r.status = spq_pkg::ST_FULL;
        end else begin
          pos = model_count;
          while (pos > 0 && held_entries[pos - 1].pri < pri) pos--;
          for (int i = model_count; i > pos; i--) held_entries[i] = held_entries[i - 1];
          held_entries[pos].id  = id;
          held_entries[pos].pri = pri;
          model_count++;
        end
      end
      spq_pkg::CMD_DELETE: begin
        if (id == '0) begin
          r.status = spq_pkg::ST_NULL;
        end else begin
          hit = -1;
          for (int i = 0; i < model_count; i++) begin
            if (hit < 0 && held_entries[i].id == id) hit = i;
          end
          if (hit < 0) r.status = spq_pkg::ST_MISS;
          else remove_entry(hit);
        end
      end
      spq_pkg::CMD_POP: begin
        if (model_count == 0) begin
          r.status = spq_pkg::ST_MISS;
        end else begin
          r.pid  = held_entries[0].id;
          r.ppri = held_entries[0].pri;
          remove_entry(0);
        end
      end
      default: ;
    endcase
    r.cnt = model_count[4:0];
    return r;
  endfunction

  function automatic logic [spq_pkg::ID_W-1:0] pick_id();
    int roll;
    roll = $urandom_range(99);
    if (roll < 5) return '0;
    if (roll < 10) return '1;
    if (roll < 50) return spq_pkg::ID_W'($urandom_range(1, 8));
    return $urandom;
  endfunction

  function automatic logic [spq_pkg::PRI_W-1:0] pick_pri();
    int roll;
    roll = $urandom_range(99);
    if (roll < 30) return spq_pkg::PRI_W'($urandom_range(0, 3));
    if (roll < 35) return '0;
    if (roll < 40) return '1;
    return $urandom;
  endfunction

  function automatic logic [spq_pkg::ID_W-1:0] pick_held_id();
    if (model_count > 0 && $urandom_range(99) < 75)
      return held_entries[$urandom_range(model_count - 1)].id;
    return pick_id();
  endfunction

  task automatic send_item(input logic [spq_pkg::CMD_W-1:0] cmd,
                           input logic [spq_pkg::ID_W-1:0] id,
                           input logic [spq_pkg::PRI_W-1:0] pri, input bit typed,
                           input spq_result_t typed_exp);
    spq_result_t predicted;
    bit          taken;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.command      <= cmd;
    in_ch.object_id    <= id;
    in_ch.priority_req <= pri;
    // ready is sampled mid-cycle, where it holds the value seen by the next edge
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = in_ch.ready;
      @(posedge clk);
    end
    predicted = apply_to_queue(cmd, id, pri);
    expected_results.push_back(typed ? typed_exp : predicted);
    status_seen[predicted.status]++;
    items_sent++;
  endtask

  task automatic send_mixed_item();
    int roll;
    roll = $urandom_range(99);
    if (roll < 45) send_item(spq_pkg::CMD_INSERT, pick_id(), pick_pri(), 1'b0, '0);
    else if (roll < 75) send_item(spq_pkg::CMD_DELETE, pick_held_id(), $urandom, 1'b0, '0);
    else if (roll < 95) send_item(spq_pkg::CMD_POP, $urandom, $urandom, 1'b0, '0);
    else send_item(CMD_UNUSED, pick_id(), pick_pri(), 1'b0, '0);
  endtask

  // fill to full and drain to empty runs push past the edge states
  task automatic run_random(input int n_items);
    int stop_at;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      case ($urandom_range(3))
        0: begin
          while (model_count < QDEPTH)
            send_item(spq_pkg::CMD_INSERT, pick_id(), pick_pri(), 1'b0, '0);
          repeat ($urandom_range(1, 3))
            send_item(spq_pkg::CMD_INSERT, pick_id(), pick_pri(), 1'b0, '0);
        end
        1: begin
          while (model_count > 0) send_item(spq_pkg::CMD_POP, $urandom, $urandom, 1'b0, '0);
          repeat ($urandom_range(1, 2))
            send_item(spq_pkg::CMD_POP, $urandom, $urandom, 1'b0, '0);
        end
        2: repeat ($urandom_range(4, 20)) send_mixed_item();
        default: repeat ($urandom_range(2, 10))
          send_item(spq_pkg::CMD_DELETE, pick_held_id(), $urandom, 1'b0, '0);
      endcase
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    spq_result_t got;
    spq_result_t want;
    out_ch.ready <= 1'b0;
    forever begin
      // valid, ready and the fields are stable mid-cycle up to the accepting edge
      @(negedge clk);
      if (out_ch.valid && out_ch.ready) begin
        got.status = spq_pkg::status_t'(out_ch.status);
        got.pid    = out_ch.popped_id;
        got.ppri   = out_ch.popped_priority;
        got.cnt    = out_ch.entry_count;
        if (expected_results.size() == 0) begin
          $error("result with nothing expected: status %0d id %h pri %h count %0d",
                 got.status, got.pid, got.ppri, got.cnt);
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          results_checked++;
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            mismatch_count++;
          end
          if (got.pid !== want.pid) begin
            $error("popped_id: expected %h, got %h", want.pid, got.pid);
            mismatch_count++;
          end
          if (got.ppri !== want.ppri) begin
            $error("popped_priority: expected %h, got %h", want.ppri, got.ppri);
            mismatch_count++;
          end
          if (got.cnt !== want.cnt) begin
            $error("entry_count: expected %0d, got %0d", want.cnt, got.cnt);
            mismatch_count++;
          end
        end
      end
      @(posedge clk);
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    spq_result_t row_exp;
    int idle_plan [3][2];
    idle_plan = '{'{21, 45}, '{45, 21}, '{0, 0}};
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.command      <= spq_pkg::CMD_INSERT;
    in_ch.object_id    <= '0;
    in_ch.priority_req <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = idle_plan[ph][0];
      recv_idle_pct = idle_plan[ph][1];
      if (ph == 0) begin
        for (int k = 0; k < N_ROWS; k++) begin
          row_exp.status = dir_rows[k].st;
          row_exp.pid    = dir_rows[k].pid;
          row_exp.ppri   = dir_rows[k].ppri;
          row_exp.cnt    = dir_rows[k].cnt;
          send_item(dir_rows[k].cmd, dir_rows[k].id, dir_rows[k].pri, dir_rows[k].typed,
                    row_exp);
        end
      end
      run_random(RANDOM_PER_PHASE);
    end
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (QDEPTH + 8) @(posedge clk);
    $display("%0d commands sent, %0d results compared", items_sent, results_checked);
    $display("outcomes: ok %0d, not found/empty %0d, full %0d, null id %0d",
             status_seen[spq_pkg::ST_OK], status_seen[spq_pkg::ST_MISS],
             status_seen[spq_pkg::ST_FULL], status_seen[spq_pkg::ST_NULL]);
    if (mismatch_count == 0) begin
      $display("sorted_priority_queue_top: match");
    end else begin
      $display("sorted_priority_queue_top: mismatch");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", expected_results.size());
    $display("sorted_priority_queue_top: mismatch");
    $finish;
  end

endmodule
